// File: rtl/ter_pkg.sv
package ter_pkg;

    // fixed point format of the vertex coordinates
    localparam int SCREEN_BITS = 12;
    localparam int FRAC_BITS   = 4;
    localparam int VTX_BITS    = SCREEN_BITS + FRAC_BITS;

    // signed widths of the edge arithmetic
    localparam int DIFF_BITS   = VTX_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 1;

    // sub-pixel offset of the pixel centre sample
    localparam logic [FRAC_BITS-1:0] HALF_SAMPLE = FRAC_BITS'(1 << (FRAC_BITS - 1));

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic emit;
    } ter_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scanning;
    } ter_status_t;

    function automatic logic [VTX_BITS-1:0] min3(
        input logic [VTX_BITS-1:0] a,
        input logic [VTX_BITS-1:0] b,
        input logic [VTX_BITS-1:0] c
    );
        logic [VTX_BITS-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [VTX_BITS-1:0] max3(
        input logic [VTX_BITS-1:0] a,
        input logic [VTX_BITS-1:0] b,
        input logic [VTX_BITS-1:0] c
    );
        logic [VTX_BITS-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

// File: rtl/ter_ctrl.sv
module ter_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 mode,
    input  ter_pkg::ter_status_t status,
    output ter_pkg::ter_cmd_t    cmd,
    output logic                 busy
);
    import ter_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.scanning)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: rtl/ter_datapath.sv
module ter_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ter_pkg::ter_cmd_t                  cmd,
    output ter_pkg::ter_status_t               status,
    input  logic [ter_pkg::VTX_BITS-1:0]       ax,
    input  logic [ter_pkg::VTX_BITS-1:0]       ay,
    input  logic [ter_pkg::VTX_BITS-1:0]       bx,
    input  logic [ter_pkg::VTX_BITS-1:0]       by_coord,
    input  logic [ter_pkg::VTX_BITS-1:0]       cx,
    input  logic [ter_pkg::VTX_BITS-1:0]       cy,
    output logic                               valid,
    output logic [ter_pkg::SCREEN_BITS-1:0]    pixel_x,
    output logic [ter_pkg::SCREEN_BITS-1:0]    pixel_y,
    output logic                               covered,
    output logic                               last
);
    import ter_pkg::*;

    // stored vertices and edge vectors, edge k runs from vertex k to vertex (k+1) mod 3
    logic        [VTX_BITS-1:0]    vx_reg [3];
    logic        [VTX_BITS-1:0]    vy_reg [3];
    logic signed [DIFF_BITS-1:0]   ex_reg [3];
    logic signed [DIFF_BITS-1:0]   ey_reg [3];

    // bounding box and scan position
    logic [SCREEN_BITS-1:0] min_x_reg;
    logic [SCREEN_BITS-1:0] max_x_reg;
    logic [SCREEN_BITS-1:0] max_y_reg;
    logic [SCREEN_BITS-1:0] scan_x_reg;
    logic [SCREEN_BITS-1:0] scan_y_reg;
    logic                   scanning_reg;

    // registered partial products
    logic signed [PROD_BITS-1:0] pa_reg [3];
    logic signed [PROD_BITS-1:0] pb_reg [3];

    // result registers
    logic                   valid_reg;
    logic [SCREEN_BITS-1:0] pixel_x_reg;
    logic [SCREEN_BITS-1:0] pixel_y_reg;
    logic                   covered_reg;
    logic                   last_reg;

    logic [VTX_BITS-1:0]         in_x [3];
    logic [VTX_BITS-1:0]         in_y [3];
    logic [VTX_BITS-1:0]         lo_x;
    logic [VTX_BITS-1:0]         hi_x;
    logic [VTX_BITS-1:0]         lo_y;
    logic [VTX_BITS-1:0]         hi_y;
    logic [VTX_BITS-1:0]         px;
    logic [VTX_BITS-1:0]         py;
    logic signed [DIFF_BITS-1:0] qx [3];
    logic signed [DIFF_BITS-1:0] qy [3];
    logic signed [CROSS_BITS-1:0] cross_prod [3];
    logic [2:0]                  neg;
    logic [2:0]                  pos;
    logic                        cov;
    logic                        fin;
    logic                        row_end;

    assign in_x[0] = ax;
    assign in_x[1] = bx;
    assign in_x[2] = cx;
    assign in_y[0] = ay;
    assign in_y[1] = by_coord;
    assign in_y[2] = cy;

    // bounding box of the incoming triangle
    always_comb
    begin
        lo_x = min3(ax, bx, cx);
        hi_x = max3(ax, bx, cx);
        lo_y = min3(ay, by_coord, cy);
        hi_y = max3(ay, by_coord, cy);
    end

    // pixel centre sample relative to each edge origin
    assign px = {scan_x_reg, HALF_SAMPLE};
    assign py = {scan_y_reg, HALF_SAMPLE};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qx[k] = $signed({1'b0, px}) - $signed({1'b0, vx_reg[k]});
            qy[k] = $signed({1'b0, py}) - $signed({1'b0, vy_reg[k]});
        end
    end

    // edge cross products and coverage from the registered products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cross_prod[k] = CROSS_BITS'(pa_reg[k]) - CROSS_BITS'(pb_reg[k]);
            neg[k]        = cross_prod[k][CROSS_BITS-1];
            pos[k]        = !cross_prod[k][CROSS_BITS-1] && (cross_prod[k] != '0);
        end
        cov = (neg == 3'b000) || (pos == 3'b000);
    end

    assign row_end = (scan_x_reg == max_x_reg);
    assign fin     = row_end && (scan_y_reg == max_y_reg);

    // triangle store, bounding box and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vx_reg[k] <= '0;
                vy_reg[k] <= '0;
            end
            min_x_reg    <= '0;
            max_x_reg    <= '0;
            max_y_reg    <= '0;
            scan_x_reg   <= '0;
            scan_y_reg   <= '0;
            scanning_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vx_reg[k] <= in_x[k];
                vy_reg[k] <= in_y[k];
            end
            min_x_reg    <= lo_x[FRAC_BITS +: SCREEN_BITS];
            max_x_reg    <= hi_x[FRAC_BITS +: SCREEN_BITS];
            max_y_reg    <= hi_y[FRAC_BITS +: SCREEN_BITS];
            scan_x_reg   <= lo_x[FRAC_BITS +: SCREEN_BITS];
            scan_y_reg   <= lo_y[FRAC_BITS +: SCREEN_BITS];
            scanning_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            if (fin)
            begin
                scanning_reg <= 1'b0;
            end
            else if (row_end)
            begin
                scan_x_reg <= min_x_reg;
                scan_y_reg <= scan_y_reg + 1'b1;
            end
            else
            begin
                scan_x_reg <= scan_x_reg + 1'b1;
            end
        end
    end

    // edge vectors, taken from the inputs at load
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ex_reg[k] <= $signed({1'b0, in_x[(k + 1) % 3]}) - $signed({1'b0, in_x[k]});
                ey_reg[k] <= $signed({1'b0, in_y[(k + 1) % 3]}) - $signed({1'b0, in_y[k]});
            end
        end
    end

    // product stage, six independent multiplies
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= ex_reg[k] * qy[k];
                pb_reg[k] <= ey_reg[k] * qx[k];
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_x_reg <= scan_x_reg;
            pixel_y_reg <= scan_y_reg;
            covered_reg <= cov;
            last_reg    <= fin;
        end
    end

    assign status.scanning = scanning_reg;
    assign valid           = valid_reg;
    assign pixel_x         = pixel_x_reg;
    assign pixel_y         = pixel_y_reg;
    assign covered         = covered_reg;
    assign last            = last_reg;

endmodule

// File: rtl/triangle_edge_rasterizer_core.sv
// triangle edge-function rasteriser
//
// command channel: an item is taken at a rising edge with start high and busy
// low. mode 0 loads the three vertices (unsigned 12.4) and sets up the
// bounding box scan; a load never raises busy. mode 1 steps to the next
// pixel of the box; a step while no scan is active is taken and dropped.
// result channel: valid is high for exactly one cycle per pixel, carrying
// pixel_x, pixel_y, covered and last. the receiver cannot hold it off.
// a step is accepted into the product state, its products are registered in
// the product registers, then the compare state loads the result registers
// and valid. busy covers the product and compare states, so a new step is
// not taken until the previous step has delivered its result.
// a new command may be issued in the same cycle that valid is shown.
// reset clears the vertices, the box and the scan; the block comes out of
// reset idle with no result pending.
module triangle_edge_rasterizer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic [ter_pkg::VTX_BITS-1:0]    ax,
    input  logic [ter_pkg::VTX_BITS-1:0]    ay,
    input  logic [ter_pkg::VTX_BITS-1:0]    bx,
    input  logic [ter_pkg::VTX_BITS-1:0]    by_coord,
    input  logic [ter_pkg::VTX_BITS-1:0]    cx,
    input  logic [ter_pkg::VTX_BITS-1:0]    cy,
    output logic                            valid,
    output logic [ter_pkg::SCREEN_BITS-1:0] pixel_x,
    output logic [ter_pkg::SCREEN_BITS-1:0] pixel_y,
    output logic                            covered,
    output logic                            last
);
    import ter_pkg::*;

    ter_cmd_t    cmd;
    ter_status_t status;

    // sequencer
    ter_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // vertex store, edge arithmetic and scan position
    ter_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by_coord (by_coord),
        .cx       (cx),
        .cy       (cy),
        .valid    (valid),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .covered  (covered),
        .last     (last)
    );

endmodule

// File: rtl/ter_checker.sv
module ter_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic valid
);

    // a result only appears while the block is free for a new command
    assert property (@(posedge clk) disable iff (!rst_n) valid |-> !busy)
        else $error("result shown while busy");

    // results never come in consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n) valid |=> !valid)
        else $error("back-to-back results");

    // no result in the cycle right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> !valid)
        else $error("result too early after transfer");

    // a load never raises busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !mode) |=> !busy)
        else $error("load raised busy");

    // busy only drops when a pixel is delivered
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> valid)
        else $error("busy dropped without a result");

endmodule

bind triangle_edge_rasterizer_core ter_checker u_ter_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .valid (valid)
);
